[design/u2l_pkg.sv]
// shared constants, types and byte classification for the utf-8 to latin-1 narrower
package u2l_pkg;

    localparam logic [7:0] QMARK           = 8'h3F;
    localparam logic [7:0] MAX_CHARS_RESET = 8'd95;
    localparam int         RES_MAX         = 4;
    localparam int         RES_IDX_W       = $clog2(RES_MAX);
    localparam int         RES_CNT_W       = $clog2(RES_MAX + 1);

    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] CODE_CONT  = 8'h80;
    localparam logic [1:0] SKIP_LEAD4 = 2'd3;

    typedef enum logic [1:0] {
        LEAD_ASCII,
        LEAD_HOLD,
        LEAD_SKIP,
        LEAD_BAD
    } lead_kind_t;

    function automatic lead_kind_t lead_kind(input logic [7:0] b);
        lead_kind_t k;
        if (!b[7])
            k = LEAD_ASCII;
        else if ((b & MASK_LEAD2) == CODE_LEAD2 || (b & MASK_LEAD3) == CODE_LEAD3)
            k = LEAD_HOLD;
        else if ((b & MASK_LEAD4) == CODE_LEAD4)
            k = LEAD_SKIP;
        else
            k = LEAD_BAD;
        return k;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & MASK_CONT) == CODE_CONT;
    endfunction

endpackage

[design/utf8_to_latin1_narrower_top.sv]
// utf-8 to latin-1 narrower: input register, one-pass decode, four-entry result buffer
// a byte's results pass through the input register and then the result buffer before they
//   are offered; a result buffer that has not drained can hold the byte in the input register
// throughput: one byte per cycle while each byte gives at most one result and m_tready is high;
//   a byte giving n results holds the input while the result buffer drains one per accepted transfer
// reset: decode state cleared, result buffer emptied, max_chars set to 95
module utf8_to_latin1_narrower_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tuser,   // end_of_string
    output logic       m_tlast,   // last_of_run
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data   // [7:0] max_chars
);

    localparam int CW = u2l_pkg::RES_CNT_W;
    localparam int IW = u2l_pkg::RES_IDX_W;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;
    logic [7:0] max_chars_reg;

    logic [7:0] held_lead_reg, held_lead_next;
    logic [7:0] held_second_reg, held_second_next;
    logic [1:0] held_count_reg, held_count_next;
    logic [1:0] skip_left_reg, skip_left_next;
    logic [7:0] emitted_count_reg, emitted_count_next;

    logic [7:0]    ent_char_reg [u2l_pkg::RES_MAX];
    logic          ent_eos_reg  [u2l_pkg::RES_MAX];
    logic [CW-1:0] cnt_reg;

    logic [7:0]    res_char [u2l_pkg::RES_MAX];
    logic          res_eos  [u2l_pkg::RES_MAX];
    logic [CW-1:0] res_n;

    logic in_take;
    logic out_take;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = (cnt_reg != '0);
    assign m_tdata   = ent_char_reg[0];
    assign m_tuser   = ent_eos_reg[0];
    assign m_tlast   = (cnt_reg == CW'(1));
    assign out_take  = m_tvalid && m_tready;
    assign in_take   = in_valid_reg &&
                       (cnt_reg == '0 || (cnt_reg == CW'(1) && m_tready));
    assign s_tready  = !in_valid_reg || in_take;

    // decode one byte into its list of results
    always_comb
    begin
        logic [7:0]    hl;
        logic [7:0]    hs;
        logic [1:0]    hc;
        logic [1:0]    sk;
        logic [7:0]    ec;
        logic [7:0]    b;
        logic          cl;
        logic [7:0]    cand [u2l_pkg::RES_MAX];
        logic [CW-1:0] nc;
        logic          lv [2];
        logic [7:0]    lb [2];
        logic [10:0]   cp2;
        logic [15:0]   cp3;

        hl = held_lead_reg;
        hs = held_second_reg;
        hc = held_count_reg;
        sk = skip_left_reg;
        ec = emitted_count_reg;
        b  = in_byte_reg;
        cl = (b == 8'd0) || in_eoi_reg;
        nc = '0;
        lv[0] = 1'b0;
        lv[1] = 1'b0;
        lb[0] = b;
        lb[1] = b;
        cp2 = {hl[4:0], b[5:0]};
        cp3 = {hl[3:0], hs[5:0], b[5:0]};
        for (int i = 0; i < u2l_pkg::RES_MAX; i++)
        begin
            cand[i]     = u2l_pkg::QMARK;
            res_char[i] = 8'd0;
            res_eos[i]  = 1'b0;
        end

        if (b != 8'd0)
        begin
            if (sk != 2'd0)
                sk = sk - 2'd1;
            else if (hc == 2'd0)
                lv[0] = 1'b1;
            else if (hc == 2'd1)
            begin
                if (!u2l_pkg::is_cont(b))
                begin
                    cand[nc[IW-1:0]] = u2l_pkg::QMARK;
                    nc = nc + CW'(1);
                    hc = 2'd0;
                    lv[0] = 1'b1;
                end
                else if ((hl & u2l_pkg::MASK_LEAD2) == u2l_pkg::CODE_LEAD2)
                begin
                    cand[nc[IW-1:0]] = (cp2[10:8] == 3'd0) ? cp2[7:0] : u2l_pkg::QMARK;
                    nc = nc + CW'(1);
                    hc = 2'd0;
                end
                else
                begin
                    hs = b;
                    hc = 2'd2;
                end
            end
            else
            begin
                if (u2l_pkg::is_cont(b))
                begin
                    cand[nc[IW-1:0]] = (cp3[15:8] == 8'd0) ? cp3[7:0] : u2l_pkg::QMARK;
                    nc = nc + CW'(1);
                    hc = 2'd0;
                end
                else
                begin
                    cand[nc[IW-1:0]] = u2l_pkg::QMARK;
                    nc = nc + CW'(1);
                    hc = 2'd0;
                    lv[0] = 1'b1;
                    lb[0] = hs;
                    lv[1] = 1'b1;
                end
            end

            // bytes worked on as new leads, in order
            for (int j = 0; j < 2; j++)
            begin
                if (lv[j])
                begin
                    case (u2l_pkg::lead_kind(lb[j]))
                        u2l_pkg::LEAD_ASCII:
                        begin
                            cand[nc[IW-1:0]] = lb[j];
                            nc = nc + CW'(1);
                        end
                        u2l_pkg::LEAD_HOLD:
                        begin
                            hl = lb[j];
                            hc = 2'd1;
                        end
                        u2l_pkg::LEAD_SKIP:
                        begin
                            cand[nc[IW-1:0]] = u2l_pkg::QMARK;
                            nc = nc + CW'(1);
                            sk = u2l_pkg::SKIP_LEAD4;
                        end
                        default:
                        begin
                            cand[nc[IW-1:0]] = u2l_pkg::QMARK;
                            nc = nc + CW'(1);
                        end
                    endcase
                end
            end
        end

        // flush held bytes on close
        if (cl)
        begin
            if (hc != 2'd0)
            begin
                cand[nc[IW-1:0]] = u2l_pkg::QMARK;
                nc = nc + CW'(1);
            end
            if (hc[1])
            begin
                cand[nc[IW-1:0]] = u2l_pkg::QMARK;
                nc = nc + CW'(1);
            end
        end

        // character limit
        res_n = '0;
        for (int i = 0; i < u2l_pkg::RES_MAX; i++)
        begin
            if (CW'(i) < nc && ec < max_chars_reg)
            begin
                res_char[res_n[IW-1:0]] = cand[i];
                res_eos[res_n[IW-1:0]]  = 1'b0;
                res_n = res_n + CW'(1);
                ec = ec + 8'd1;
            end
        end

        if (cl)
        begin
            res_char[res_n[IW-1:0]] = 8'd0;
            res_eos[res_n[IW-1:0]]  = 1'b1;
            res_n = res_n + CW'(1);
            hl = 8'd0;
            hs = 8'd0;
            hc = 2'd0;
            sk = 2'd0;
            ec = 8'd0;
        end

        held_lead_next     = hl;
        held_second_next   = hs;
        held_count_next    = hc;
        skip_left_next     = sk;
        emitted_count_next = ec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            max_chars_reg     <= u2l_pkg::MAX_CHARS_RESET;
            held_lead_reg     <= 8'd0;
            held_second_reg   <= 8'd0;
            held_count_reg    <= 2'd0;
            skip_left_reg     <= 2'd0;
            emitted_count_reg <= 8'd0;
            cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_chars_reg <= cfg_data;
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (in_take)
                in_valid_reg <= 1'b0;
            if (in_take)
            begin
                held_lead_reg     <= held_lead_next;
                held_second_reg   <= held_second_next;
                held_count_reg    <= held_count_next;
                skip_left_reg     <= skip_left_next;
                emitted_count_reg <= emitted_count_next;
                cnt_reg           <= res_n;
            end
            else if (out_take)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // payload: input register and result buffer
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
        if (in_take)
        begin
            for (int i = 0; i < u2l_pkg::RES_MAX; i++)
            begin
                ent_char_reg[i] <= res_char[i];
                ent_eos_reg[i]  <= res_eos[i];
            end
        end
        else if (out_take)
        begin
            for (int i = 0; i < u2l_pkg::RES_MAX - 1; i++)
            begin
                ent_char_reg[i] <= ent_char_reg[i+1];
                ent_eos_reg[i]  <= ent_eos_reg[i+1];
            end
        end
    end

endmodule

[dv/utf8_to_latin1_narrower_top_test.sv]
// self-checking testbench for the utf-8 to latin-1 narrower: stream driver, responder, scoreboard
module utf8_to_latin1_narrower_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       last;
    } latin1_char_t;

    typedef enum {
        UNIT_ASCII,
        UNIT_TWO,
        UNIT_THREE,
        UNIT_FOUR,
        UNIT_NOISE,
        UNIT_BROKEN,
        UNIT_STRAY,
        UNIT_OPEN
    } unit_kind_t;

    class latin1_scoreboard;
        logic [7:0]   max_chars;
        logic [7:0]   lead_byte;
        logic [7:0]   second_byte;
        int unsigned  held;
        int unsigned  skip;
        int unsigned  emitted;
        latin1_char_t step_chars[$];
        latin1_char_t expected_chars[$];
        int unsigned  errors;
        int unsigned  results_checked;
        int unsigned  texts_closed;

        function new();
            max_chars       = u2l_pkg::MAX_CHARS_RESET;
            lead_byte       = '0;
            second_byte     = '0;
            held            = 0;
            skip            = 0;
            emitted         = 0;
            errors          = 0;
            results_checked = 0;
            texts_closed    = 0;
        endfunction

        function void emit_char(input logic [15:0] cp);
            latin1_char_t r;
            r.ch   = (cp <= 16'h00FF) ? cp[7:0] : u2l_pkg::QMARK;
            r.eos  = 1'b0;
            r.last = 1'b0;
            if (emitted < max_chars)
            begin
                step_chars.push_back(r);
                emitted++;
            end
        endfunction

        function void take_lead(input logic [7:0] b);
            if (!b[7])
                emit_char({8'h00, b});
            else if ((b & u2l_pkg::MASK_LEAD2) == u2l_pkg::CODE_LEAD2 ||
                     (b & u2l_pkg::MASK_LEAD3) == u2l_pkg::CODE_LEAD3)
            begin
                lead_byte = b;
                held      = 1;
            end
            else if ((b & u2l_pkg::MASK_LEAD4) == u2l_pkg::CODE_LEAD4)
            begin
                emit_char({8'h00, u2l_pkg::QMARK});
                skip = int'(u2l_pkg::SKIP_LEAD4);
            end
            else
                emit_char({8'h00, u2l_pkg::QMARK});
        endfunction

        function void decode_byte(input logic [7:0] b);
            logic cont;
            cont = (b & u2l_pkg::MASK_CONT) == u2l_pkg::CODE_CONT;
            if (skip != 0)
                skip--;
            else if (held == 0)
                take_lead(b);
            else if (held == 1)
            begin
                if (!cont)
                begin
                    emit_char({8'h00, u2l_pkg::QMARK});
                    held = 0;
                    take_lead(b);
                end
                else if ((lead_byte & u2l_pkg::MASK_LEAD2) == u2l_pkg::CODE_LEAD2)
                begin
                    emit_char({5'b0, lead_byte[4:0], b[5:0]});
                    held = 0;
                end
                else
                begin
                    second_byte = b;
                    held        = 2;
                end
            end
            else
            begin
                if (cont)
                begin
                    emit_char({lead_byte[3:0], second_byte[5:0], b[5:0]});
                    held = 0;
                end
                else
                begin
                    emit_char({8'h00, u2l_pkg::QMARK});
                    held = 0;
                    take_lead(second_byte);
                    take_lead(b);
                end
            end
        endfunction

        function void close_text();
            latin1_char_t r;
            for (int k = 0; k < held && k < 2; k++)
                emit_char({8'h00, u2l_pkg::QMARK});
            r.ch   = 8'h00;
            r.eos  = 1'b1;
            r.last = 1'b0;
            step_chars.push_back(r);
            lead_byte   = '0;
            second_byte = '0;
            held        = 0;
            skip        = 0;
            emitted     = 0;
            texts_closed++;
        endfunction

        function void note_request(input logic [7:0] b, input logic eoi);
            step_chars.delete();
            if (b == 8'h00)
                close_text();
            else
            begin
                decode_byte(b);
                if (eoi)
                    close_text();
            end
            if (step_chars.size() > 0)
                step_chars[step_chars.size() - 1].last = 1'b1;
            foreach (step_chars[i])
                expected_chars.push_back(step_chars[i]);
        endfunction

        function void check_result(input logic [7:0] ch, input logic eos, input logic last);
            latin1_char_t e;
            results_checked++;
            if (expected_chars.size() == 0)
            begin
                $error("result with nothing expected: out_char %h end_of_string %b last_of_run %b",
                       ch, eos, last);
                errors++;
                return;
            end
            e = expected_chars.pop_front();
            if (ch !== e.ch)
            begin
                $error("out_char: expected %h, actual %h", e.ch, ch);
                errors++;
            end
            if (eos !== e.eos)
            begin
                $error("end_of_string: expected %b, actual %b", e.eos, eos);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last_of_run: expected %b, actual %b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    latin1_scoreboard sb;
    logic             calm_in;
    logic             calm_out;
    int unsigned      bytes_sent;
    int unsigned      cycle_count = 0;

    utf8_to_latin1_narrower_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoi;
        do @(posedge clk); while (!s_tready);
        sb.note_request(b, eoi);
        bytes_sent++;
        gap = calm_in ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_chars.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_max_chars(input logic [7:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.max_chars = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_text(inout int sent);
        logic [7:0] q[$];
        int         n_units;
        int         r;
        unit_kind_t kind;
        logic       by_flag;
        logic       eoi;
        n_units = $urandom_range(1, 8);
        repeat (n_units)
        begin
            r    = $urandom_range(0, 10);
            kind = (r < 7) ? unit_kind_t'(r % 4) : unit_kind_t'(r - 3);
            case (kind)
                UNIT_ASCII:
                    q.push_back(8'($urandom_range(1, 127)));
                UNIT_TWO:
                begin
                    q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                    q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                UNIT_THREE:
                begin
                    q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    repeat (2) q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                UNIT_FOUR:
                begin
                    q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                    repeat (3) q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                UNIT_NOISE:
                    q.push_back(8'($urandom_range(1, 255)));
                UNIT_BROKEN:
                begin
                    q.push_back(8'($urandom_range(8'hC0, 8'hEF)));
                    if ($urandom_range(0, 1))
                        q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    q.push_back($urandom_range(0, 1) ? 8'($urandom_range(1, 127))
                                                     : 8'($urandom_range(8'hC0, 8'hFF)));
                end
                UNIT_STRAY:
                    q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                     : 8'($urandom_range(8'hF8, 8'hFF)));
                default:
                    q.push_back(8'($urandom_range(8'hC0, 8'hF7)));
            endcase
        end
        by_flag = $urandom_range(0, 1);
        if (!by_flag)
            q.push_back(8'h00);
        foreach (q[i])
        begin
            eoi = (i == q.size() - 1) && (by_flag || $urandom_range(0, 1));
            send_byte(q[i], eoi);
            sent++;
        end
    endtask

    task automatic random_phase(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            send_random_text(sent);
        end
    endtask

    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser, m_tlast);
            stall = calm_out ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 8'h00;
        calm_in    = 1'b0;
        calm_out   = 1'b0;
        bytes_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // plain ascii, two- and three-byte forms, a code point above 0xff, overlong zero
        send_byte(8'h41, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hC5, 1'b0);
        send_byte(8'h93, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        // four-byte lead and its skip, stray and invalid leads
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // bad continuation after a lead, then after two held bytes with the end flag
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b1);
        // skip cut short by a zero byte, open lead flushed, zero byte with end flag
        send_byte(8'hF0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hE2, 1'b1);
        send_byte(8'h00, 1'b1);
        settle();

        write_max_chars(8'd1);
        random_phase(18);
        settle();
        write_max_chars(8'd255);
        random_phase(18);
        settle();
        write_max_chars(8'($urandom_range(2, 8)));
        random_phase(18);
        settle();
        write_max_chars(8'($urandom_range(1, 255)));
        random_phase(18);
        settle();
        repeat (10) @(posedge clk);

        $display("sent %0d source bytes closing %0d strings, checked %0d results",
                 bytes_sent, sb.texts_closed, sb.results_checked);
        $display("max_chars covered reset value, 1, 255 and two random settings");
        if (sb.errors == 0 && sb.expected_chars.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
